FILE: design/folded_substring_scanner_macros.svh
// Assertion macros for the folded substring scanner checker.
// Depends on nothing; included by the checker file only.
`ifndef FOLDED_SUBSTRING_SCANNER_MACROS_SVH
`define FOLDED_SUBSTRING_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fss checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fss checker: next-cycle property failed");

`endif

FILE: design/fss_pkg.sv
// Shared types, constants and the case-folding function of the scanner.
// No dependencies; used by every module of the block.
package fss_pkg;

  localparam int MAX_TERM = 32;
  localparam int MAX_LINE = 4096;

  localparam int CU_W    = 16;
  localparam int IDX_W   = 13;
  localparam int START_W = 12;

  localparam logic [CU_W-1:0] CU_UPPER_A = 16'h0041;
  localparam logic [CU_W-1:0] CU_UPPER_Z = 16'h005A;
  localparam logic [CU_W-1:0] CU_LOWER_A = 16'h0061;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_LINE   = 2'd2
  } req_e;

  typedef struct packed {
    req_e              req_type;
    logic [CU_W-1:0]   code_unit;
    logic              last;
    logic [IDX_W-1:0]  from_pos;
    logic [IDX_W-1:0]  limit_pos;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [START_W-1:0] hit_start;
    logic               line_done;
    logic               first_found;
    logic [IDX_W-1:0]   first_index;
    logic               last_found;
    logic [IDX_W-1:0]   last_index;
    logic               self_overlap;
  } out_item_t;

  // Broadcast controls for every cell of the chain.
  typedef struct packed {
    logic term_clr;
    logic term_app;
    logic line_step;
    logic pm_clr;
    logic use_fold;
  } cell_ctrl_t;

  // Handoff from one cell to the next.
  typedef struct packed {
    logic pm;
    logic ovx;
    logic ovf;
  } cell_link_t;

  // Per-cell status seen by the top level.
  typedef struct packed {
    logic pm_step;
    logic rx_d;
    logic rf_d;
  } cell_stat_t;

  function automatic logic [CU_W-1:0] fold_unit(input logic [CU_W-1:0] c);
    logic [CU_W-1:0] r;
    r = c;
    if (c >= CU_UPPER_A && c <= CU_UPPER_Z) begin
      r = c - CU_UPPER_A + CU_LOWER_A;
    end
    return r;
  endfunction

endpackage

FILE: design/folded_substring_scanner.sv
// Top level of the folded substring scanner: cell chain, line tracking
// and result buffer. Depends on fss_pkg, fss_cell and fss_out_buf.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+-----------------------
//   in      | input     | in_valid_i/in_ready_o | fss_pkg::in_item_t
//   out     | output    | out_valid_o/out_ready_i | fss_pkg::out_item_t
//   cfg     | input     | cfg_we_i (no wait)   | cfg_data_i (case_sensitive)
//
// Every accepted beat yields one result beat, shown on out in the cycle
// after acceptance when no older result waits; one beat per cycle is
// sustained while out_ready_i stays high. A two-entry result buffer keeps
// in_ready_o high while one result waits.
// Reset clears control state at once; term units are written before use,
// so there is no clearing pass.
module folded_substring_scanner #(
  parameter int MaxTerm = fss_pkg::MAX_TERM,
  parameter int MaxLine = fss_pkg::MAX_LINE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fss_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fss_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i
);

  // Widths: term length, line position, and a common compare width.
  localparam int TLW = $clog2(MaxTerm + 1);
  localparam int LW  = $clog2(MaxLine + 1);
  localparam int PW  = (LW > fss_pkg::IDX_W) ? LW : fss_pkg::IDX_W;
  localparam logic [TLW-1:0] TermFull = TLW'(MaxTerm);
  localparam logic [LW-1:0]  LineEnd  = LW'(MaxLine);

  // Configuration register.
  logic case_sens_q;

  // Term and line state.
  logic [TLW-1:0]             len_q, len_d;
  logic                       sel_fold_q, sel_fold_d;
  logic [LW-1:0]              pos_q, pos_d, pos_n;
  logic [fss_pkg::IDX_W-1:0]  from_q, from_d, limit_q, limit_d;
  logic                       ff_q, ff_d, ff_n, lf_q, lf_d, lf_n;
  logic [fss_pkg::IDX_W-1:0]  fi_q, fi_d, fi_n, li_q, li_d, li_n;

  // Beat decode.
  logic accept, push_ready;
  logic is_clear, is_app, is_line, app_ok, in_range, do_match, line_done;
  logic [fss_pkg::IDX_W-1:0] eff_from, eff_limit;
  logic [PW-1:0] st, lim_m1, li_min;
  logic hit;
  logic self_ov;

  fss_pkg::cell_ctrl_t      ctrl;
  fss_pkg::out_item_t       res;
  logic [fss_pkg::CU_W-1:0] code_fold;

  // Chain wiring: link[j] feeds cell j; link[0] is the constant head.
  fss_pkg::cell_link_t link_w [MaxTerm+1];
  fss_pkg::cell_stat_t stat_w [MaxTerm];
  logic [MaxTerm-1:0]  pm_step_w, rx_d_w, rf_d_w, tail_w, r_sel;

  assign accept    = in_valid_i & push_ready;
  assign in_ready_o = push_ready;

  always_comb begin
    is_clear = 1'b0;
    is_app   = 1'b0;
    is_line  = 1'b0;
    if (accept) begin
      case (in_item_i.req_type)
        fss_pkg::REQ_CLEAR:  is_clear = 1'b1;
        fss_pkg::REQ_APPEND: is_app   = 1'b1;
        fss_pkg::REQ_LINE:   is_line  = 1'b1;
        default: ;
      endcase
    end
  end

  // Drop appends once the term is full; the partial matches still clear.
  assign app_ok    = is_app & (len_q != TermFull);
  assign in_range  = (pos_q < LineEnd);
  assign do_match  = is_line & in_range & (len_q != '0);
  assign line_done = is_line & in_item_i.last;

  // The first unit of a line carries the search bounds; hold them after.
  assign eff_from  = (pos_q == '0) ? in_item_i.from_pos  : from_q;
  assign eff_limit = (pos_q == '0) ? in_item_i.limit_pos : limit_q;

  assign code_fold = fss_pkg::fold_unit(in_item_i.code_unit);

  always_comb begin
    ctrl.term_clr  = is_clear;
    ctrl.term_app  = app_ok;
    ctrl.line_step = do_match;
    // Clear partial matches on any term change, past the line end,
    // and after the last unit of a line.
    ctrl.pm_clr    = is_clear | is_app | (is_line & (!in_range | in_item_i.last));
    ctrl.use_fold  = !case_sens_q;
  end

  assign link_w[0] = '{pm: 1'b1, ovx: 1'b1, ovf: 1'b1};

  for (genvar j = 0; j < MaxTerm; j++) begin : g_cell
    fss_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .code_unit_i (in_item_i.code_unit),
      .code_fold_i (code_fold),
      .wr_en_i     (len_q == TLW'(j)),
      .active_i    (len_q > TLW'(j)),
      .link_i      (link_w[j]),
      .link_o      (link_w[j+1]),
      .stat_o      (stat_w[j])
    );
    assign pm_step_w[j] = stat_w[j].pm_step;
    assign rx_d_w[j]    = stat_w[j].rx_d;
    assign rf_d_w[j]    = stat_w[j].rf_d;
    // The tail cell of the current term signals a complete match.
    assign tail_w[j]    = (len_q == TLW'(j + 1));
  end

  assign hit = do_match & (|(pm_step_w & tail_w));
  assign st  = PW'(pos_q) + PW'(1) - PW'(len_q);

  // Self-overlap follows the folding in force at the last accepted append.
  assign sel_fold_d = app_ok ? !case_sens_q : sel_fold_q;
  assign r_sel      = sel_fold_d ? rf_d_w : rx_d_w;
  // Cell 0 stands for the shift equal to the length, which never counts.
  assign self_ov    = |(r_sel & ~MaxTerm'(1));

  assign pos_n  = (is_line & in_range) ? (pos_q + LW'(1)) : pos_q;
  assign lim_m1 = PW'(eff_limit) - PW'(1);
  assign li_min = (lim_m1 < PW'(pos_n)) ? lim_m1 : PW'(pos_n);

  always_comb begin
    ff_n = ff_q;
    fi_n = fi_q;
    lf_n = lf_q;
    li_n = li_q;
    if (hit) begin
      if (!ff_q && (st >= PW'(eff_from))) begin
        ff_n = 1'b1;
        fi_n = st[fss_pkg::IDX_W-1:0];
      end
      if (st < PW'(eff_limit)) begin
        lf_n = 1'b1;
        li_n = st[fss_pkg::IDX_W-1:0];
      end
    end
    // Empty term: forward hit at from, backward hit just under limit.
    if (line_done && (len_q == '0)) begin
      if (PW'(eff_from) <= PW'(pos_n)) begin
        ff_n = 1'b1;
        fi_n = eff_from;
      end
      if (eff_limit != '0) begin
        lf_n = 1'b1;
        li_n = li_min[fss_pkg::IDX_W-1:0];
      end
    end
  end

  always_comb begin
    len_d   = len_q;
    pos_d   = pos_q;
    from_d  = from_q;
    limit_d = limit_q;
    ff_d    = ff_q;
    fi_d    = fi_q;
    lf_d    = lf_q;
    li_d    = li_q;
    if (is_clear) begin
      len_d = '0;
    end else if (app_ok) begin
      len_d = len_q + TLW'(1);
    end
    if (is_line) begin
      from_d  = eff_from;
      limit_d = eff_limit;
      if (in_item_i.last) begin
        // Reset line state for the next line.
        pos_d = '0;
        ff_d  = 1'b0;
        fi_d  = '0;
        lf_d  = 1'b0;
        li_d  = '0;
      end else begin
        pos_d = pos_n;
        ff_d  = ff_n;
        fi_d  = fi_n;
        lf_d  = lf_n;
        li_d  = li_n;
      end
    end
  end

  always_comb begin
    res.hit          = hit;
    res.hit_start    = hit ? st[fss_pkg::START_W-1:0] : '0;
    res.line_done    = line_done;
    res.first_found  = line_done & ff_n;
    res.first_index  = (line_done & ff_n) ? fi_n : '0;
    res.last_found   = line_done & lf_n;
    res.last_index   = (line_done & lf_n) ? li_n : '0;
    res.self_overlap = self_ov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_sens_q <= 1'b1;
      len_q       <= '0;
      sel_fold_q  <= 1'b0;
      pos_q       <= '0;
      from_q      <= '0;
      limit_q     <= '0;
      ff_q        <= 1'b0;
      fi_q        <= '0;
      lf_q        <= 1'b0;
      li_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case_sens_q <= cfg_data_i;
      end
      len_q      <= len_d;
      sel_fold_q <= sel_fold_d;
      pos_q      <= pos_d;
      from_q     <= from_d;
      limit_q    <= limit_d;
      ff_q       <= ff_d;
      fi_q       <= fi_d;
      lf_q       <= lf_d;
      li_q       <= li_d;
    end
  end

  // Hold finished results; accept the next beat while one result waits.
  fss_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (accept),
    .push_ready_o (push_ready),
    .push_item_i  (res),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_item_o   (out_item_o)
  );

endmodule

FILE: design/fss_cell.sv
// One cell of the matcher chain: a term unit, its partial-match bit and
// two self-overlap flags (exact and folded). Depends on fss_pkg.
module fss_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fss_pkg::cell_ctrl_t           ctrl_i,
  input  logic [fss_pkg::CU_W-1:0]      code_unit_i,
  input  logic [fss_pkg::CU_W-1:0]      code_fold_i,
  input  logic                          wr_en_i,
  input  logic                          active_i,
  input  fss_pkg::cell_link_t           link_i,
  output fss_pkg::cell_link_t           link_o,
  output fss_pkg::cell_stat_t           stat_o
);

  logic [fss_pkg::CU_W-1:0] unit_q;
  logic pm_q, pm_d;
  logic rx_q, rx_d;
  logic rf_q, rf_d;
  logic eqx, eqf, eq_line, pm_step;

  assign eqx     = (unit_q == code_unit_i);
  assign eqf     = (fss_pkg::fold_unit(unit_q) == code_fold_i);
  assign eq_line = ctrl_i.use_fold ? eqf : eqx;
  assign pm_step = link_i.pm & eq_line & active_i;

  always_comb begin
    pm_d = pm_q;
    if (ctrl_i.pm_clr) begin
      pm_d = 1'b0;
    end else if (ctrl_i.line_step) begin
      pm_d = pm_step;
    end
    rx_d = rx_q;
    rf_d = rf_q;
    if (ctrl_i.term_clr) begin
      rx_d = 1'b0;
      rf_d = 1'b0;
    end else if (ctrl_i.term_app) begin
      rx_d = link_i.ovx;
      rf_d = link_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
      rx_q <= 1'b0;
      rf_q <= 1'b0;
    end else begin
      pm_q <= pm_d;
      rx_q <= rx_d;
      rf_q <= rf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.term_app && wr_en_i) begin
      unit_q <= code_unit_i;
    end
  end

  assign link_o.pm  = pm_q;
  assign link_o.ovx = rx_q & eqx;
  assign link_o.ovf = rf_q & eqf;

  assign stat_o.pm_step = pm_step;
  assign stat_o.rx_d    = rx_d;
  assign stat_o.rf_d    = rf_d;

endmodule

FILE: design/fss_out_buf.sv
// Two-entry result buffer: head register plus skid register.
// Depends on fss_pkg for the result beat type.
module fss_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  fss_pkg::out_item_t  push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output fss_pkg::out_item_t  pop_item_o
);

  logic               head_vld_q, skid_vld_q;
  fss_pkg::out_item_t head_q, skid_q;
  logic               push, pop;

  assign push_ready_o = !skid_vld_q;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = head_vld_q & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (pop) begin
          skid_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (head_vld_q && !pop) begin
          skid_vld_q <= 1'b1;
        end else begin
          head_vld_q <= 1'b1;
        end
      end else if (pop) begin
        head_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        head_q <= skid_q;
      end
    end else if (push) begin
      if (head_vld_q && !pop) begin
        skid_q <= push_item_i;
      end else begin
        head_q <= push_item_i;
      end
    end
  end

  assign pop_valid_o = head_vld_q;
  assign pop_item_o  = head_q;

endmodule

FILE: design/fss_checker.sv
// Port-level checker for the folded substring scanner, bound to the top.
// Depends on fss_pkg and folded_substring_scanner_macros.svh.
`include "folded_substring_scanner_macros.svh"

module fss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input fss_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input fss_pkg::out_item_t out_item_o
);

  logic in_beat;
  logic line_beat;

  assign in_beat   = in_valid_i & in_ready_o;
  assign line_beat = in_item_i.req_type == fss_pkg::REQ_LINE;

  // A stalled result beat holds.
  `FSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  // No result beat appears without an accepted input beat.
  `FSS_ASSERT_NEXT(a_no_invent, clk_i, rst_ni, !out_valid_o && !in_beat, !out_valid_o)
  // An empty output side always takes the next beat.
  `FSS_ASSERT_SAME(a_empty_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
  // A term beat taken into an empty buffer shows no hit and no line end.
  `FSS_ASSERT_NEXT(a_term_no_hit, clk_i, rst_ni, in_beat && !out_valid_o && !line_beat, out_valid_o && !out_item_o.hit && !out_item_o.line_done)

endmodule

bind folded_substring_scanner fss_checker u_fss_checker (.*);

FILE: dv/folded_substring_scanner_test.sv
// Self-checking testbench for folded_substring_scanner: term edits, line scans,
// case folding and the find/rfind results. Depends on fss_pkg and the RTL only.
module folded_substring_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fss_pkg::*;

  // Request code that the block must ignore apart from reporting self-overlap.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [CU_W-1:0] CH_AT = 16'h0040;
  localparam logic [CU_W-1:0] CH_A  = CU_UPPER_A;
  localparam logic [CU_W-1:0] CH_B  = 16'h0042;
  localparam logic [CU_W-1:0] CH_Z  = CU_UPPER_Z;
  localparam logic [CU_W-1:0] CH_LB = 16'h005B;
  localparam logic [CU_W-1:0] CH_BQ = 16'h0060;
  localparam logic [CU_W-1:0] CH_a  = CU_LOWER_A;
  localparam logic [CU_W-1:0] CH_b  = 16'h0062;
  localparam logic [CU_W-1:0] CH_z  = 16'h007A;
  localparam logic [CU_W-1:0] CH_LC = 16'h007B;

  localparam int unsigned HOLD_CYCLES = 80;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT = 1000; // cycles without any beat moving

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;
  logic      cfg_we_i;
  logic      cfg_data_i;

  always #1 clk_i = ~clk_i;

  folded_substring_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Scanner prediction. Mirrors the block's state: the term, a shift-and vector
  // of live prefixes, the self-overlap shifts, and the per-line search state.
  // ---------------------------------------------------------------------------
  logic                 exact_cmp = 1'b1;  // case_sensitive as last written
  logic [CU_W-1:0]      pat_units [MAX_TERM];
  int unsigned          pat_len = 0;
  logic [MAX_TERM-1:0]  live_prefix = '0;
  logic [MAX_TERM-1:0]  border_shifts = '0;
  int unsigned          col = 0;           // units of the current line so far
  logic [IDX_W-1:0]     anchor_from = '0;
  logic [IDX_W-1:0]     anchor_limit = '0;
  logic                 fwd_hit = 1'b0;
  int unsigned          fwd_at = 0;
  logic                 bwd_hit = 1'b0;
  int unsigned          bwd_at = 0;

  out_item_t pending_results [$];  // predicted result beats, oldest first
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned idle_pct = 36;      // shared idling rate of sender and receiver
  logic        hold_results = 1'b0;

  // Lower ASCII A-Z when folding is on; everything else passes unchanged.
  function automatic logic [CU_W-1:0] fold_cu(input logic [CU_W-1:0] c);
    if (!exact_cmp && c >= CU_UPPER_A && c <= CU_UPPER_Z) begin
      return c - CU_UPPER_A + CU_LOWER_A;
    end
    return c;
  endfunction

  function automatic logic [MAX_TERM-1:0] prefix_mask(input int unsigned n);
    logic [MAX_TERM:0] m;
    m = ({{MAX_TERM{1'b0}}, 1'b1} << n) - 1'b1;
    return m[MAX_TERM-1:0];
  endfunction

  function automatic out_item_t predict_scan(input in_item_t it);
    out_item_t           r;
    logic [MAX_TERM-1:0] eq;
    logic [CU_W-1:0]     c;
    logic                ok;
    int unsigned         st;
    r = '0;
    case (it.req_type)
      REQ_CLEAR: begin
        pat_len = 0;
        border_shifts = '0;
        live_prefix = '0;
      end
      REQ_APPEND: begin
        // Drop appends to a full term; rebuild overlap with today's folding.
        if (pat_len < MAX_TERM) begin
          pat_units[pat_len] = it.code_unit;
          pat_len++;
          border_shifts = '0;
          for (int s = 1; s < pat_len; s++) begin
            ok = 1'b1;
            for (int i = 0; i + s < pat_len; i++) begin
              if (fold_cu(pat_units[i + s]) != fold_cu(pat_units[i])) ok = 1'b0;
            end
            border_shifts[s] = ok;
          end
        end
        live_prefix = '0;
      end
      REQ_LINE: begin
        if (col == 0) begin
          anchor_from = it.from_pos;
          anchor_limit = it.limit_pos;
        end
        if (col < MAX_LINE) begin
          if (pat_len > 0) begin
            c = fold_cu(it.code_unit);
            eq = '0;
            for (int i = 0; i < pat_len; i++) eq[i] = (fold_cu(pat_units[i]) == c);
            live_prefix = ((live_prefix << 1) | 1'b1) & eq & prefix_mask(pat_len);
            if (live_prefix[pat_len-1]) begin
              st = col + 1 - pat_len;
              r.hit = 1'b1;
              r.hit_start = st[START_W-1:0];
              if (!fwd_hit && st >= anchor_from) begin
                fwd_hit = 1'b1;
                fwd_at = st;
              end
              if (st < anchor_limit) begin
                bwd_hit = 1'b1;
                bwd_at = st;
              end
            end
          end
          col++;
        end else begin
          // Past the line limit: no matching, and break any partial match.
          live_prefix = '0;
        end
        if (it.last) begin
          // Empty term behaves like find/rfind on an empty needle.
          if (pat_len == 0) begin
            if (anchor_from <= col) begin
              fwd_hit = 1'b1;
              fwd_at = anchor_from;
            end
            if (anchor_limit > 0) begin
              bwd_hit = 1'b1;
              bwd_at = (anchor_limit - 1 < col) ? anchor_limit - 1 : col;
            end
          end
          r.line_done = 1'b1;
          r.first_found = fwd_hit;
          r.first_index = fwd_hit ? fwd_at[IDX_W-1:0] : '0;
          r.last_found = bwd_hit;
          r.last_index = bwd_hit ? bwd_at[IDX_W-1:0] : '0;
          col = 0;
          live_prefix = '0;
          fwd_hit = 1'b0;
          fwd_at = 0;
          bwd_hit = 1'b0;
          bwd_at = 0;
        end
      end
      default: ;
    endcase
    r.self_overlap = |(border_shifts & prefix_mask(pat_len) & ~{{MAX_TERM-1{1'b0}}, 1'b1});
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Tasks are entered and left at a rising edge; outputs are
  // sampled on the falling edge, when nothing is changing.
  // ---------------------------------------------------------------------------
  function automatic in_item_t beat_of(input req_e r, input logic [CU_W-1:0] cu,
                                       input logic lst, input int unsigned f,
                                       input int unsigned l);
    in_item_t it;
    it.req_type = r;
    it.code_unit = cu;
    it.last = lst;
    it.from_pos = f[IDX_W-1:0];
    it.limit_pos = l[IDX_W-1:0];
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    logic taken;
    // Idle a random number of cycles, then hold valid until the beat is taken.
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_results.push_back(predict_scan(it));
    if (it.req_type != req_e'(REQ_UNUSED)) beats_sent++;
  endtask

  // Drop valid and wait until every predicted result has been consumed.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Only called with the block idle.
  task automatic write_folding(input logic exact);
    cfg_we_i <= 1'b1;
    cfg_data_i <= exact;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    exact_cmp = exact;
  endtask

  // Mostly small positions, with the extremes mixed in.
  function automatic int unsigned pick_pos();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 0;
    if (roll < 20) return MAX_LINE;
    if (roll < 30) return $urandom_range(MAX_LINE, 0);
    return $urandom_range(45, 0);
  endfunction

  // A small alphabet keeps matches frequent; the rest probes folding edges
  // and the full 16-bit range.
  function automatic logic [CU_W-1:0] pick_unit();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return CH_a;
    if (roll < 55) return CH_b;
    if (roll < 70) return CH_A;
    if (roll < 80) return CH_B;
    if (roll < 90) return 16'($urandom_range(CH_LC, CH_AT));
    return 16'($urandom_range(16'hFFFF, 0));
  endfunction

  // Stream one line; from/limit only count on the first unit, so scramble
  // them elsewhere. poke_pct injects term edits between units.
  task automatic stream_line(input logic [CU_W-1:0] units [$], input int unsigned f,
                             input int unsigned l, input int unsigned poke_pct);
    for (int k = 0; k < units.size(); k++) begin
      if (k > 0 && $urandom_range(99) < poke_pct) begin
        send_beat(beat_of($urandom_range(1, 0) ? REQ_APPEND : REQ_CLEAR, pick_unit(),
                          1'($urandom), pick_pos(), pick_pos()));
      end
      send_beat(beat_of(REQ_LINE, units[k], k == units.size() - 1,
                        (k == 0) ? f : pick_pos(), (k == 0) ? l : pick_pos()));
    end
  endtask

  task automatic load_term(input int unsigned n);
    send_beat(beat_of(REQ_CLEAR, pick_unit(), 1'($urandom), pick_pos(), pick_pos()));
    repeat (n) send_beat(beat_of(REQ_APPEND, pick_unit(), 1'($urandom), pick_pos(),
                                 pick_pos()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty term, extremes of the fields, the unused request code and a term
  // edit in the middle of a line.
  task automatic test_directed();
    write_folding(1'b1);
    send_beat(beat_of(REQ_LINE, CH_LC, 1'b1, 0, 0));
    send_beat(beat_of(REQ_LINE, 16'h0000, 1'b0, 3, MAX_LINE));
    send_beat(beat_of(REQ_LINE, 16'hFFFF, 1'b1, 0, 0));
    send_beat(beat_of(REQ_LINE, CH_z, 1'b1, MAX_LINE, 1));
    send_beat(beat_of(req_e'(REQ_UNUSED), 16'hFFFF, 1'b1, 8191, 8191));
    // Term "aBa" overlaps itself at shift two.
    send_beat(beat_of(REQ_APPEND, CH_a, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, CH_B, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, CH_a, 1'b1, 0, 0));
    send_beat(beat_of(REQ_LINE, CH_a, 1'b0, 1, 3));
    send_beat(beat_of(REQ_LINE, CH_B, 1'b0, 0, 0));
    send_beat(beat_of(REQ_LINE, CH_a, 1'b0, 0, 0));
    send_beat(beat_of(REQ_LINE, CH_B, 1'b0, 0, 0));
    send_beat(beat_of(REQ_LINE, CH_a, 1'b1, 0, 0));
    send_beat(beat_of(req_e'(REQ_UNUSED), 16'h0000, 1'b0, 0, 0));
    // Change the term mid-line: partials drop, the line keeps its position.
    send_beat(beat_of(REQ_CLEAR, 16'h0000, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, 16'hFFFF, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, 16'h0000, 1'b0, 0, 0));
    send_beat(beat_of(REQ_LINE, 16'hFFFF, 1'b0, 0, MAX_LINE));
    send_beat(beat_of(REQ_LINE, 16'h0000, 1'b0, 0, 0));
    send_beat(beat_of(REQ_LINE, 16'hFFFF, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, CH_z, 1'b0, 0, 0));
    send_beat(beat_of(REQ_LINE, 16'h0000, 1'b0, 0, 0));
    send_beat(beat_of(REQ_LINE, CH_z, 1'b1, 0, 0));
    wait_quiet();
  endtask

  // Folding on both sides, and self_overlap keeping the folding of its append.
  task automatic test_folding();
    logic [CU_W-1:0] units [$];
    write_folding(1'b0);
    send_beat(beat_of(REQ_CLEAR, 16'h0000, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, CH_A, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, CH_a, 1'b0, 0, 0));
    units = {CH_a, CH_A, CH_A};
    stream_line(units, 0, MAX_LINE, 0);
    wait_quiet();
    write_folding(1'b1);
    units = {CH_a, CH_A};
    stream_line(units, 0, MAX_LINE, 0);
    send_beat(beat_of(REQ_APPEND, CH_Z, 1'b0, 0, 0));
    units = {CH_AT, CH_LB, CH_A, CH_a, CH_Z, CH_BQ};
    stream_line(units, 0, MAX_LINE, 0);
    wait_quiet();
    write_folding(1'b0);
    units = {CH_A, CH_a, CH_z, CH_BQ, CH_LC, CH_a, CH_A, CH_Z};
    stream_line(units, 2, 6, 0);
    wait_quiet();
  endtask

  // Fill the term to its limit; one more append is ignored.
  task automatic test_full_term();
    logic [CU_W-1:0] units [$];
    send_beat(beat_of(REQ_CLEAR, 16'h0000, 1'b0, 0, 0));
    repeat (MAX_TERM) send_beat(beat_of(REQ_APPEND, CH_a, 1'b0, 0, 0));
    send_beat(beat_of(REQ_APPEND, CH_b, 1'b0, 0, 0));
    units = {};
    repeat (MAX_TERM + 2) units.push_back(CH_A);
    stream_line(units, 0, MAX_LINE, 0);
    wait_quiet();
  endtask

  // Hold the result side off for a long stretch while lines keep coming, so the
  // block backs up into its input.
  task automatic test_output_stall();
    logic [CU_W-1:0] units [$];
    load_term(2);
    hold_results = 1'b1;
    repeat (3) begin
      units = {};
      repeat (10) units.push_back(pick_unit());
      stream_line(units, pick_pos(), pick_pos(), 0);
    end
    wait_quiet();
  endtask

  // Mostly well-formed traffic: new terms and lines over a small alphabet, with
  // stray items, mid-line edits and folding changes between phases.
  task automatic test_random_traffic(input int unsigned n_beats);
    logic [CU_W-1:0] units [$];
    int unsigned     stop_at;
    int unsigned     next_phase;
    int unsigned     phase;
    int unsigned     roll;
    int unsigned     n;
    stop_at = beats_sent + n_beats;
    next_phase = beats_sent;
    phase = 0;
    while (beats_sent < stop_at) begin
      if (beats_sent >= next_phase) begin
        wait_quiet();
        write_folding(phase[0]);
        // One phase runs with no idling on either side.
        idle_pct = (phase == 2) ? 0 : 36;
        phase++;
        next_phase = beats_sent + 220;
      end
      roll = $urandom_range(99);
      if (roll < 12) begin
        roll = $urandom_range(99);
        n = (roll < 10) ? 0 : (roll < 90) ? $urandom_range(4, 1) :
                                           $urandom_range(MAX_TERM + 1, 5);
        load_term(n);
      end else if (roll < 17) begin
        send_beat(beat_of(req_e'($urandom_range(3, 0)), 16'($urandom_range(16'hFFFF, 0)),
                          1'($urandom), $urandom_range(MAX_LINE, 0),
                          $urandom_range(MAX_LINE, 0)));
      end else begin
        n = ($urandom_range(99) < 95) ? $urandom_range(40, 1) : $urandom_range(200, 41);
        units = {};
        repeat (n) units.push_back(pick_unit());
        stream_line(units, pick_pos(), pick_pos(), 2);
      end
    end
    wait_quiet();
    idle_pct = 36;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        hold_results = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [CU_W-1:0] want,
                             input logic [CU_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // A result beat moves at the next rising edge when valid and ready are both
  // high at the falling edge before it.
  always @(negedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_item_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, out_item_o.hit);
        check_field("hit_start", want.hit_start, out_item_o.hit_start);
        check_field("line_done", want.line_done, out_item_o.line_done);
        check_field("first_found", want.first_found, out_item_o.first_found);
        check_field("first_index", want.first_index, out_item_o.first_index);
        check_field("last_found", want.last_found, out_item_o.last_found);
        check_field("last_index", want.last_index, out_item_o.last_index);
        check_field("self_overlap", want.self_overlap, out_item_o.self_overlap);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_folding();
    test_full_term();
    test_output_stall();
    test_random_traffic(1150);

    // Let any stray result beat show up before the verdict.
    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/fss_pkg.sv
design/fss_cell.sv
design/fss_out_buf.sv
design/folded_substring_scanner.sv
design/fss_checker.sv
dv/folded_substring_scanner_test.sv
